>>> rtl/core/terminal_escape_sequence_parser_defines.svh
// assertion macros for the terminal escape sequence parser checker
// no dependencies; included by files that hold concurrent assertions
`ifndef TERMINAL_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH
`define TERMINAL_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH

// plain property, checked at every rising clock edge outside reset
`define TESP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, antecedent and consequent in the same cycle
`define TESP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `TESP_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define TESP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `TESP_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> rtl/core/tesp_pkg.sv
// shared types, widths, character and result codes of the escape sequence parser
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package tesp_pkg;

    // parameter defaults
    localparam int MAX_VALUES_DEF = 4;
    localparam int VALUE_BITS_DEF = 16;

    // fixed word widths and the number of result values
    localparam int CH_W        = 8;
    localparam int CODE_W      = 5;
    localparam int COUNT_W     = 3;
    localparam int OUT_VALUES  = 4;
    localparam int OUT_VALUE_W = 16;

    // parser modes
    typedef enum logic [3:0] {
        MODE_GROUND = 4'b0001,
        MODE_ESC    = 4'b0010,
        MODE_SQUARE = 4'b0100,
        MODE_NUMBER = 4'b1000
    } t_mode;

    // characters with a role of their own, and the wrap mode value
    localparam logic [CH_W-1:0] CH_ESC     = 8'h1B;
    localparam logic [CH_W-1:0] CH_BRACKET = 8'h5B;
    localparam logic [CH_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam int              WRAP_MODE  = 7;

    // result codes
    localparam logic [CODE_W-1:0] C_PARTIAL     = 5'd0;
    localparam logic [CODE_W-1:0] C_INVALID     = 5'd1;
    localparam logic [CODE_W-1:0] C_TAB         = 5'd2;
    localparam logic [CODE_W-1:0] C_BS          = 5'd3;
    localparam logic [CODE_W-1:0] C_CR          = 5'd4;
    localparam logic [CODE_W-1:0] C_LF          = 5'd5;
    localparam logic [CODE_W-1:0] C_VT          = 5'd6;
    localparam logic [CODE_W-1:0] C_FF          = 5'd7;
    localparam logic [CODE_W-1:0] C_BEL         = 5'd8;
    localparam logic [CODE_W-1:0] C_ETX         = 5'd9;
    localparam logic [CODE_W-1:0] C_EOT         = 5'd10;
    localparam logic [CODE_W-1:0] C_DEL         = 5'd11;
    localparam logic [CODE_W-1:0] C_SAVE        = 5'd12;
    localparam logic [CODE_W-1:0] C_RESTORE     = 5'd13;
    localparam logic [CODE_W-1:0] C_SCROLL_DOWN = 5'd14;
    localparam logic [CODE_W-1:0] C_SCROLL_UP   = 5'd15;
    localparam logic [CODE_W-1:0] C_UP          = 5'd16;
    localparam logic [CODE_W-1:0] C_DOWN        = 5'd17;
    localparam logic [CODE_W-1:0] C_RIGHT       = 5'd18;
    localparam logic [CODE_W-1:0] C_LEFT        = 5'd19;
    localparam logic [CODE_W-1:0] C_DOWN_HOME   = 5'd20;
    localparam logic [CODE_W-1:0] C_UP_HOME     = 5'd21;
    localparam logic [CODE_W-1:0] C_SET_COL     = 5'd22;
    localparam logic [CODE_W-1:0] C_HOME        = 5'd23;
    localparam logic [CODE_W-1:0] C_ERASE_LINE  = 5'd24;
    localparam logic [CODE_W-1:0] C_ERASE_DISP  = 5'd25;
    localparam logic [CODE_W-1:0] C_SCROLL_SET  = 5'd26;
    localparam logic [CODE_W-1:0] C_WRAP_SET    = 5'd27;
    localparam logic [CODE_W-1:0] C_WRAP_CLR    = 5'd28;
    localparam logic [CODE_W-1:0] C_MAX         = C_WRAP_CLR;

endpackage

`default_nettype wire

>>> rtl/core/tesp_ifs.sv
// valid/ready channel interfaces for input bytes and parser results
// depends on tesp_pkg
`default_nettype none

interface tesp_byte_if import tesp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface tesp_result_if import tesp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CODE_W-1:0]      code;
    logic                   in_sequence;
    logic [COUNT_W-1:0]     value_count;
    logic [OUT_VALUE_W-1:0] value0;
    logic [OUT_VALUE_W-1:0] value1;
    logic [OUT_VALUE_W-1:0] value2;
    logic [OUT_VALUE_W-1:0] value3;

    modport source (output valid, output code, output in_sequence, output value_count,
                    output value0, output value1, output value2, output value3,
                    input ready);
    modport sink   (input valid, input code, input in_sequence, input value_count,
                    input value0, input value1, input value2, input value3,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/terminal_escape_sequence_parser.sv
// top level of the terminal escape sequence parser
// depends on tesp_pkg and the channel interfaces in tesp_ifs
//
// usage
//   i_byte carries one received byte per word; o_result gives exactly one
//   result word per byte, in order: command code, open-sequence flag,
//   parameter count and the first four parameter values
//   the accepting edge loads the input register; the parse logic then runs
//   into the result register once it is free or its word is being taken
//   throughput is one byte per cycle while o_result.ready does not stall;
//   the parser state (mode, count, values) updates with each accepted byte,
//   so back-to-back bytes never wait on each other
//   the input register keeps taking words while a result waits: i_byte.ready
//   only drops when both the input and result registers are full and
//   o_result.ready is low, and everything holds until the receiver takes it
//   reset puts the parser in the ground state and empties both registers;
//   the values are zeroed lazily by the first byte after reset or after any
//   complete result
`default_nettype none

module terminal_escape_sequence_parser import tesp_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tesp_byte_if.sink      i_byte,
    tesp_result_if.source  o_result
);

    localparam int CNT_W = $clog2(MAX_VALUES + 1);

    // input register
    logic            r_in_valid;
    logic [CH_W-1:0] r_in_ch;

    // parser state
    t_mode                 r_mode, n_mode;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [VALUE_BITS-1:0] r_values [MAX_VALUES];
    logic [VALUE_BITS-1:0] n_values [MAX_VALUES];
    logic                  r_clear, n_clear;

    // result register
    logic                   r_out_valid;
    logic [CODE_W-1:0]      r_out_code;
    logic                   r_out_seq;
    logic [COUNT_W-1:0]     r_out_count;
    logic [OUT_VALUE_W-1:0] r_out_val [OUT_VALUES];

    // parse logic
    logic                   w_adv, w_fire;
    logic [CNT_W-1:0]       w_cur_count, w_cnt1;
    logic [VALUE_BITS-1:0]  w_cur_values [MAX_VALUES];
    logic                   w_is_digit, w_is_semi, w_wrap_ok;
    logic [VALUE_BITS-1:0]  w_digit;
    logic [CODE_W-1:0]      w_code;
    logic [OUT_VALUE_W-1:0] w_out_val [OUT_VALUES];

    // final letter of a bracket sequence
    function automatic logic [CODE_W-1:0] f_final(input logic [CH_W-1:0] ch,
                                                  input logic wrap_ok);
        logic [CODE_W-1:0] code;
        case (ch)
            "s":     code = C_SAVE;
            "u":     code = C_RESTORE;
            "A":     code = C_UP;
            "B":     code = C_DOWN;
            "C":     code = C_RIGHT;
            "D":     code = C_LEFT;
            "E":     code = C_DOWN_HOME;
            "F":     code = C_UP_HOME;
            "G":     code = C_SET_COL;
            "f":     code = C_HOME;
            "H":     code = C_HOME;
            "K":     code = C_ERASE_LINE;
            "J":     code = C_ERASE_DISP;
            "r":     code = C_SCROLL_SET;
            "h":     code = wrap_ok ? C_WRAP_SET : C_INVALID;
            "l":     code = wrap_ok ? C_WRAP_CLR : C_INVALID;
            default: code = C_INVALID;
        endcase
        return code;
    endfunction

    // handshake: the parse stage moves whenever the result register is free
    assign w_adv        = !r_out_valid || o_result.ready;
    assign w_fire       = r_in_valid && w_adv;
    assign i_byte.ready = !r_in_valid || w_adv;

    // pending clear applied before the byte is looked at
    assign w_cur_count = r_clear ? '0 : r_count;
    always_comb begin
        for (int k = 0; k < MAX_VALUES; k++) begin
            w_cur_values[k] = r_clear ? '0 : r_values[k];
        end
    end

    assign w_is_digit = r_in_ch inside {[CH_ZERO:CH_NINE]};
    assign w_is_semi  = (r_in_ch == CH_SEMI);
    assign w_digit    = VALUE_BITS'(r_in_ch[3:0]);
    assign w_wrap_ok  = (w_cur_values[0] == VALUE_BITS'(WRAP_MODE));
    // a digit with no value started opens the first one
    assign w_cnt1     = (w_cur_count == '0) ? CNT_W'(1) : w_cur_count;

    always_comb begin
        n_mode   = r_mode;
        n_count  = w_cur_count;
        n_values = w_cur_values;
        w_code   = C_INVALID;
        case (r_mode)
            MODE_GROUND: begin
                case (r_in_ch)
                    CH_ESC: begin
                        n_mode = MODE_ESC;
                        w_code = C_PARTIAL;
                    end
                    8'd9:    w_code = C_TAB;
                    8'd8:    w_code = C_BS;
                    8'd13:   w_code = C_CR;
                    8'd10:   w_code = C_LF;
                    8'd11:   w_code = C_VT;
                    8'd12:   w_code = C_FF;
                    8'd7:    w_code = C_BEL;
                    8'd3:    w_code = C_ETX;
                    8'd4:    w_code = C_EOT;
                    8'd127:  w_code = C_DEL;
                    default: w_code = C_INVALID;
                endcase
            end
            MODE_ESC: begin
                case (r_in_ch)
                    CH_BRACKET: begin
                        n_mode = MODE_SQUARE;
                        w_code = C_PARTIAL;
                    end
                    "7":     w_code = C_SAVE;
                    "8":     w_code = C_RESTORE;
                    "D":     w_code = C_SCROLL_DOWN;
                    "M":     w_code = C_SCROLL_UP;
                    "H":     w_code = C_TAB;
                    default: w_code = C_INVALID;
                endcase
            end
            MODE_SQUARE, MODE_NUMBER: begin
                if (w_is_semi) begin
                    // leading separator or one value too many
                    if (w_cur_count == '0 || w_cur_count >= CNT_W'(MAX_VALUES)) begin
                        w_code = C_INVALID;
                    end else begin
                        n_count = w_cur_count + CNT_W'(1);
                        n_mode  = MODE_NUMBER;
                        w_code  = C_PARTIAL;
                    end
                end else if (w_is_digit) begin
                    n_count = w_cnt1;
                    n_mode  = MODE_NUMBER;
                    w_code  = C_PARTIAL;
                    // value * 10 + digit, wrapping at the value width
                    for (int k = 0; k < MAX_VALUES; k++) begin
                        if (CNT_W'(k + 1) == w_cnt1) begin
                            n_values[k] = (w_cur_values[k] << 3) + (w_cur_values[k] << 1)
                                          + w_digit;
                        end
                    end
                end else begin
                    if (r_mode == MODE_NUMBER) begin
                        n_count = w_cnt1;
                    end
                    w_code = f_final(r_in_ch, w_wrap_ok);
                end
            end
            default: begin
                n_mode = MODE_GROUND;
                w_code = C_INVALID;
            end
        endcase
        // any complete result ends the sequence
        n_clear = (w_code != C_PARTIAL);
        if (n_clear) begin
            n_mode = MODE_GROUND;
        end
    end

    // result values, fixed at four words of sixteen bits
    for (genvar k = 0; k < OUT_VALUES; k++) begin : g_out
        if (k < MAX_VALUES) begin : g_used
            assign w_out_val[k] = OUT_VALUE_W'(n_values[k]);
        end else begin : g_unused
            assign w_out_val[k] = '0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.ready) begin
            r_in_ch <= i_byte.ch;
        end
    end

    // parser state; a set clear flag stands in for zeroed values after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_GROUND;
            r_clear <= 1'b1;
        end else if (w_fire) begin
            r_mode  <= n_mode;
            r_clear <= n_clear;
        end
        if (w_fire) begin
            r_count  <= n_count;
            r_values <= n_values;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) begin
            r_out_code  <= w_code;
            r_out_seq   <= (w_code == C_PARTIAL);
            r_out_count <= COUNT_W'(n_count);
            r_out_val   <= w_out_val;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.code        = r_out_code;
    assign o_result.in_sequence = r_out_seq;
    assign o_result.value_count = r_out_count;
    assign o_result.value0      = r_out_val[0];
    assign o_result.value1      = r_out_val[1];
    assign o_result.value2      = r_out_val[2];
    assign o_result.value3      = r_out_val[3];

endmodule

`default_nettype wire

>>> rtl/core/tesp_checker.sv
// port-level assertions for the terminal escape sequence parser, bound to the top
// depends on tesp_pkg and terminal_escape_sequence_parser_defines.svh
`default_nettype none
`include "terminal_escape_sequence_parser_defines.svh"

module tesp_checker import tesp_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               i_ready,
    input wire logic [CODE_W-1:0]  i_code,
    input wire logic               i_in_sequence,
    input wire logic [COUNT_W-1:0] i_value_count
);

    localparam logic [COUNT_W-1:0] MAX_SHOWN =
        (MAX_VALUES > 7) ? COUNT_W'(7) : COUNT_W'(MAX_VALUES);

    // open-sequence flag tracks the partial code
    `TESP_ASSERT_IMPL(a_seq_flag, i_clk, i_rst_n, i_valid, i_in_sequence == (i_code == C_PARTIAL), "in_sequence disagrees with code")

    // no code beyond the last command
    `TESP_ASSERT_IMPL(a_code_range, i_clk, i_rst_n, i_valid, i_code <= C_MAX, "result code out of range")

    // never more parameters than configured
    `TESP_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, i_valid, i_value_count <= MAX_SHOWN, "value count above limit")

    // a stalled result word holds
    `TESP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_code), "stalled result changed")

endmodule

bind terminal_escape_sequence_parser tesp_checker #(
    .MAX_VALUES (MAX_VALUES)
) u_tesp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_result.valid),
    .i_ready       (o_result.ready),
    .i_code        (o_result.code),
    .i_in_sequence (o_result.in_sequence),
    .i_value_count (o_result.value_count)
);

`default_nettype wire
